// ===== hdl/plq_pkg.sv =====
// plq_pkg: types, codes and helpers shared by the price level order queue
// no dependencies; imported by price_level_order_queue_core and price_level_order_queue_core_tb
`timescale 1ns / 1ps

package plq_pkg;

  localparam logic [2:0] KIND_ADD    = 3'd0;
  localparam logic [2:0] KIND_REMOVE = 3'd1;
  localparam logic [2:0] KIND_MODIFY = 3'd2;
  localparam logic [2:0] KIND_EXEC   = 3'd3;
  localparam logic [2:0] KIND_LOOKUP = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_PRICE     = 3'd2;
  localparam logic [2:0] ST_BELOW_EXE = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_DUPLICATE = 3'd5;
  localparam logic [2:0] ST_NO_FILL   = 3'd6;

  localparam int TOTAL_W = 38;
  localparam int COUNT_W = 7;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] size;
    logic [31:0] executed;
  } entry_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [31:0]        id;
    logic [31:0]        filled;
    logic [31:0]        remaining;
    logic               done;
    logic [TOTAL_W-1:0] total;
    logic [COUNT_W-1:0] count;
    logic               last;
  } result_t;

  function automatic logic [31:0] rem_of(input logic [31:0] sz, input logic [31:0] ex);
    rem_of = (sz > ex) ? (sz - ex) : 32'd0;
  endfunction

endpackage

// ===== hdl/plq_ram.sv =====
// plq_ram: generic simple dual port ram, one write and one registered read port
// no dependencies; read returns the old contents on a same-address write
`timescale 1ns / 1ps

module plq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/plq_slots.sv =====
// plq_slots: occupancy bits of the queue slots and lowest free slot pick
// depends on nothing but its parameter
`timescale 1ns / 1ps

module plq_slots #(
  parameter int MAX_ORDERS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          set,
  input  logic [$clog2(MAX_ORDERS)-1:0] set_slot,
  input  logic                          clr,
  input  logic [$clog2(MAX_ORDERS)-1:0] clr_slot,
  output logic [$clog2(MAX_ORDERS)-1:0] free_slot
);

  localparam int SW = $clog2(MAX_ORDERS);

  logic [MAX_ORDERS-1:0] used;

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      if (set) begin
        used[set_slot] <= 1'b1;
      end
      if (clr) begin
        used[clr_slot] <= 1'b0;
      end
    end
  end

  // lowest free index wins
  always_comb begin
    free_slot = '0;
    for (int i = MAX_ORDERS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_slot = SW'(i);
      end
    end
  end

endmodule

// ===== hdl/price_level_order_queue_core.sv =====
// price_level_order_queue_core: time-priority order queue at one price level
// depends on plq_pkg, plq_ram and plq_slots
//
//   channel   dir  handshake               contents
//   s_axis    in   s_axis_tvalid/tready    one request (kind in tuser)
//   m_axis    out  m_axis_tvalid/tready    result items, tlast on the final one
//   cfg       in   cfg_valid/cfg_ready     level price, always ready
//
// one request at a time; requests by id walk the linked queue in the entry ram,
// one entry a cycle, from position 0 at the head; execute fills orders from the
// head. a stalled m_axis holds the sequencer at each step that emits a result.
// reset clears all control state and the occupancy bits; the ram needs
// no clearing.
`timescale 1ns / 1ps

module price_level_order_queue_core #(
  parameter int MAX_ORDERS = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // id, price, quantity, executed amount
  input  logic [2:0]   s_axis_tuser,   // kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [143:0] m_axis_tdata,   // result id, filled amount, remaining amount,
                                       // done flag, level total, order count, zero pad
  output logic [2:0]   m_axis_tuser,   // status
  output logic         m_axis_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data        // level_price
);

  import plq_pkg::*;

  localparam int SW = $clog2(MAX_ORDERS);
  localparam int CW = $clog2(MAX_ORDERS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_WALK = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_EFIN = 3'd4;

  logic [2:0]  state, state_next;
  logic [31:0] level_price;

  logic [2:0]  kind_q;
  logic [31:0] id_q, price_q, qty_q, exe_q;

  logic [SW-1:0] rd_addr, rd_addr_next;
  logic [SW-1:0] head, head_next, tail, tail_next, prev, prev_next;
  logic          has_prev, has_prev_next;
  logic [CW-1:0] count, count_next, walk, walk_next;
  logic [TOTAL_W-1:0] total, total_next;
  logic [31:0]   left, left_next;

  logic    pend_valid, pend_valid_next;
  result_t pend, pend_next;
  result_t out_q, e_res;
  logic    out_valid, emit, ofree;

  entry_t        rdata, d_wdata;
  logic          d_we;
  logic [SW-1:0] d_waddr;
  logic [SW-1:0] nrdata, n_waddr, n_wdata;
  logic          n_we;
  logic          v_set, v_clr;
  logic [SW-1:0] free_slot;

  logic        nf_req;
  logic [31:0] r_cur, x_amt, new_exe, new_rem;
  logic        x_done;
  logic [CW-1:0] cnt_after;
  logic [31:0] left_after;
  logic        cont;

  plq_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_ORDERS)) u_entry_ram (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(rd_addr_next), .rdata(rdata)
  );

  plq_ram #(.WIDTH(SW), .DEPTH(MAX_ORDERS)) u_next_ram (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(rd_addr_next), .rdata(nrdata)
  );

  plq_slots #(.MAX_ORDERS(MAX_ORDERS)) u_slots (
    .clk(clk), .rst(rst), .set(v_set), .set_slot(free_slot),
    .clr(v_clr), .clr_slot(rd_addr), .free_slot(free_slot)
  );

  assign ofree         = !out_valid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;

  // one step of a fill against the current head
  assign r_cur      = rem_of(rdata.size, rdata.executed);
  assign x_amt      = (left < r_cur) ? left : r_cur;
  assign new_exe    = rdata.executed + x_amt;
  assign x_done     = (new_exe >= rdata.size);
  assign new_rem    = x_done ? 32'd0 : (rdata.size - new_exe);
  assign cnt_after  = x_done ? (count - 1'b1) : count;
  assign left_after = left - x_amt;
  assign cont       = (cnt_after != '0) && (left_after != 32'd0);

  always_comb begin
    state_next      = state;
    rd_addr_next    = rd_addr;
    head_next       = head;
    tail_next       = tail;
    prev_next       = prev;
    has_prev_next   = has_prev;
    count_next      = count;
    walk_next       = walk;
    total_next      = total;
    left_next       = left;
    pend_valid_next = pend_valid;
    pend_next       = pend;
    emit            = 1'b0;
    e_res           = '0;
    e_res.id        = id_q;
    e_res.last      = 1'b1;
    d_we            = 1'b0;
    d_waddr         = rd_addr;
    d_wdata         = rdata;
    n_we            = 1'b0;
    n_waddr         = prev;
    n_wdata         = nrdata;
    v_set           = 1'b0;
    v_clr           = 1'b0;
    nf_req          = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        unique case (kind_q) inside
          KIND_ADD, KIND_REMOVE, KIND_MODIFY, KIND_LOOKUP: begin
            if (kind_q == KIND_ADD && price_q != level_price) begin
              if (ofree) begin
                emit         = 1'b1;
                e_res.status = ST_PRICE;
                state_next   = S_IDLE;
              end
            end else if (count == '0) begin
              nf_req = 1'b1;
            end else begin
              rd_addr_next  = head;
              walk_next     = '0;
              has_prev_next = 1'b0;
              state_next    = S_WALK;
            end
          end
          KIND_EXEC: begin
            if (count == '0 || qty_q == 32'd0) begin
              if (ofree) begin
                emit         = 1'b1;
                e_res.status = ST_NO_FILL;
                e_res.id     = 32'd0;
                state_next   = S_IDLE;
              end
            end else begin
              rd_addr_next = head;
              left_next    = qty_q;
              state_next   = S_EXEC;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_WALK: begin
        if (rdata.id == id_q) begin
          if (ofree) begin
            emit       = 1'b1;
            state_next = S_IDLE;
            case (kind_q)
              KIND_ADD: begin
                e_res.status = ST_DUPLICATE;
              end
              KIND_REMOVE: begin
                total_next = total - TOTAL_W'(r_cur);
                if (!has_prev) begin
                  head_next = nrdata;
                end else begin
                  n_we = 1'b1;
                end
                if (rd_addr == tail) begin
                  tail_next = has_prev ? prev : '0;
                end
                v_clr      = 1'b1;
                count_next = count - 1'b1;
                if (count == CW'(1)) begin
                  head_next = '0;
                  tail_next = '0;
                end
                e_res.status = ST_OK;
              end
              KIND_MODIFY: begin
                if (qty_q < rdata.executed) begin
                  e_res.status = ST_BELOW_EXE;
                end else begin
                  d_we         = 1'b1;
                  d_wdata.size = qty_q;
                  total_next   = total - TOTAL_W'(r_cur)
                               + TOTAL_W'(rem_of(qty_q, rdata.executed));
                  e_res.status    = ST_OK;
                  e_res.remaining = rem_of(qty_q, rdata.executed);
                end
              end
              default: begin
                e_res.status    = ST_OK;
                e_res.remaining = r_cur;
              end
            endcase
          end
        end else if (CW'(walk + 1'b1) >= count) begin
          nf_req = 1'b1;
        end else begin
          prev_next     = rd_addr;
          has_prev_next = 1'b1;
          walk_next     = walk + 1'b1;
          rd_addr_next  = nrdata;
        end
      end
      S_EXEC: begin
        if (ofree) begin
          if (x_amt != 32'd0) begin
            d_we             = 1'b1;
            d_wdata.executed = new_exe;
            total_next       = total - TOTAL_W'(x_amt);
            if (pend_valid) begin
              emit       = 1'b1;
              e_res      = pend;
              e_res.last = 1'b0;
            end
            pend_valid_next     = 1'b1;
            pend_next.status    = ST_OK;
            pend_next.id        = rdata.id;
            pend_next.filled    = x_amt;
            pend_next.remaining = new_rem;
            pend_next.done      = x_done;
            pend_next.total     = total - TOTAL_W'(x_amt);
            pend_next.count     = COUNT_W'(cnt_after);
            pend_next.last      = 1'b1;
          end
          left_next = left_after;
          if (x_done) begin
            v_clr        = 1'b1;
            count_next   = cnt_after;
            head_next    = nrdata;
            rd_addr_next = nrdata;
            if (cnt_after == '0) begin
              head_next = '0;
              tail_next = '0;
            end
          end
          if (!cont) begin
            state_next = S_EFIN;
          end
        end
      end
      S_EFIN: begin
        if (ofree) begin
          emit = 1'b1;
          if (pend_valid) begin
            e_res = pend;
          end else begin
            e_res.status = ST_NO_FILL;
            e_res.id     = 32'd0;
          end
          pend_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // id not in the queue
    if (nf_req && ofree) begin
      emit       = 1'b1;
      state_next = S_IDLE;
      if (kind_q != KIND_ADD) begin
        e_res.status = ST_NOT_FOUND;
      end else if (count >= CW'(MAX_ORDERS)) begin
        e_res.status = ST_FULL;
      end else begin
        d_we             = 1'b1;
        d_waddr          = free_slot;
        d_wdata.id       = id_q;
        d_wdata.size     = qty_q;
        d_wdata.executed = exe_q;
        v_set            = 1'b1;
        if (count != '0) begin
          n_we    = 1'b1;
          n_waddr = tail;
          n_wdata = free_slot;
        end else begin
          head_next = free_slot;
        end
        tail_next       = free_slot;
        count_next      = count + 1'b1;
        total_next      = total + TOTAL_W'(rem_of(qty_q, exe_q));
        e_res.status    = ST_OK;
        e_res.remaining = rem_of(qty_q, exe_q);
      end
    end

    // items from the pending holder carry their own totals
    if (emit && !(state == S_EXEC || (state == S_EFIN && pend_valid))) begin
      e_res.total = total_next;
      e_res.count = COUNT_W'(count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      level_price <= '0;
      rd_addr     <= '0;
      head        <= '0;
      tail        <= '0;
      prev        <= '0;
      has_prev    <= 1'b0;
      count       <= '0;
      walk        <= '0;
      total       <= '0;
      left        <= '0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state      <= state_next;
      rd_addr    <= rd_addr_next;
      head       <= head_next;
      tail       <= tail_next;
      prev       <= prev_next;
      has_prev   <= has_prev_next;
      count      <= count_next;
      walk       <= walk_next;
      total      <= total_next;
      left       <= left_next;
      pend_valid <= pend_valid_next;
      out_valid  <= emit || (out_valid && !m_axis_tready);
      if (cfg_valid) begin
        level_price <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend <= pend_next;
    if (emit) begin
      out_q <= e_res;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      kind_q  <= s_axis_tuser;
      id_q    <= s_axis_tdata[31:0];
      price_q <= s_axis_tdata[63:32];
      qty_q   <= s_axis_tdata[95:64];
      exe_q   <= s_axis_tdata[127:96];
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {2'b00, out_q.count, out_q.total, out_q.done,
                          out_q.remaining, out_q.filled, out_q.id};

endmodule

// ===== dv/price_level_order_queue_core_tb.sv =====
// price_level_order_queue_core_tb: self-checking bench for the price level order queue
// depends on plq_pkg and price_level_order_queue_core; predicts each result in-bench
`timescale 1ns / 1ps

module price_level_order_queue_core_tb;
  import plq_pkg::*;

  localparam int DEPTH = 64;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [143:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [31:0]  cfg_data = '0;

  price_level_order_queue_core #(.MAX_ORDERS(DEPTH)) u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // shadow copy of the level
  logic [31:0]        lvl_price;
  logic [31:0]        sh_id[DEPTH];
  logic [31:0]        sh_size[DEPTH];
  logic [31:0]        sh_exe[DEPTH];
  bit                 sh_valid[DEPTH];
  int                 sh_next[DEPTH];
  int                 sh_head, sh_tail, sh_count;
  logic [TOTAL_W-1:0] sh_total;

  result_t pending_results[$];
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int cycles = 0;

  function automatic logic [31:0] open_qty(input logic [31:0] sz, input logic [31:0] ex);
    return (sz > ex) ? sz - ex : 32'd0;
  endfunction

  function automatic bit locate(input logic [31:0] id, output int slot, output int prev,
                                output bit has_prev);
    int p, q;
    bit hp;
    p = sh_head;
    q = 0;
    hp = 0;
    slot = 0;
    prev = 0;
    has_prev = 0;
    for (int i = 0; i < sh_count; i++) begin
      if (sh_valid[p] && sh_id[p] == id) begin
        slot = p;
        prev = q;
        has_prev = hp;
        return 1;
      end
      q = p;
      hp = 1;
      p = sh_next[p];
    end
    return 0;
  endfunction

  function automatic void unlink(input int s, input int prev, input bit has_prev);
    if (!has_prev) sh_head = sh_next[s];
    else sh_next[prev] = sh_next[s];
    if (s == sh_tail) sh_tail = has_prev ? prev : 0;
    sh_valid[s] = 0;
    if (sh_count > 0) sh_count--;
    if (sh_count == 0) begin
      sh_head = 0;
      sh_tail = 0;
    end
  endfunction

  function automatic result_t mk(input logic [2:0] st, input logic [31:0] id,
                                 input logic [31:0] filled, input logic [31:0] rem,
                                 input logic done);
    result_t r;
    r.status = st;
    r.id = id;
    r.filled = filled;
    r.remaining = rem;
    r.done = done;
    r.total = sh_total;
    r.count = COUNT_W'(sh_count);
    r.last = 1'b0;
    return r;
  endfunction

  // applies one accepted request to the shadow level and queues its results
  function automatic void apply_request(input logic [2:0] kind, input logic [31:0] id,
                                        input logic [31:0] price, input logic [31:0] qty,
                                        input logic [31:0] exe);
    result_t batch[$];
    int s, prev, fs;
    bit hp, found, done;
    logic [31:0] left, r, x, oid;
    found = locate(id, s, prev, hp);
    case (kind)
      KIND_ADD: begin
        if (price != lvl_price) batch.insert(batch.size(), mk(ST_PRICE, id, 0, 0, 0));
        else if (found) batch.insert(batch.size(), mk(ST_DUPLICATE, id, 0, 0, 0));
        else if (sh_count >= DEPTH) batch.insert(batch.size(), mk(ST_FULL, id, 0, 0, 0));
        else begin
          fs = 0;
          while (sh_valid[fs]) fs++;
          sh_id[fs] = id;
          sh_size[fs] = qty;
          sh_exe[fs] = exe;
          sh_valid[fs] = 1;
          sh_next[fs] = 0;
          if (sh_count == 0) sh_head = fs;
          else sh_next[sh_tail] = fs;
          sh_tail = fs;
          sh_count++;
          sh_total += open_qty(qty, exe);
          batch.insert(batch.size(), mk(ST_OK, id, 0, open_qty(qty, exe), 0));
        end
      end
      KIND_REMOVE: begin
        if (!found) batch.insert(batch.size(), mk(ST_NOT_FOUND, id, 0, 0, 0));
        else begin
          sh_total -= open_qty(sh_size[s], sh_exe[s]);
          unlink(s, prev, hp);
          batch.insert(batch.size(), mk(ST_OK, id, 0, 0, 0));
        end
      end
      KIND_MODIFY: begin
        if (!found) batch.insert(batch.size(), mk(ST_NOT_FOUND, id, 0, 0, 0));
        else if (qty < sh_exe[s]) batch.insert(batch.size(), mk(ST_BELOW_EXE, id, 0, 0, 0));
        else begin
          sh_total -= open_qty(sh_size[s], sh_exe[s]);
          sh_size[s] = qty;
          sh_total += open_qty(qty, sh_exe[s]);
          batch.insert(batch.size(), mk(ST_OK, id, 0, open_qty(qty, sh_exe[s]), 0));
        end
      end
      KIND_EXEC: begin
        left = qty;
        while (sh_count > 0 && left > 0 && batch.size() < DEPTH) begin
          s = sh_head;
          r = open_qty(sh_size[s], sh_exe[s]);
          x = (left < r) ? left : r;
          oid = sh_id[s];
          if (x > 0) begin
            sh_exe[s] += x;
            sh_total -= x;
            left -= x;
          end
          done = sh_exe[s] >= sh_size[s];
          // orders with nothing left at the head leave silently
          if (done) unlink(s, 0, 0);
          if (x > 0)
            batch.insert(batch.size(),
                         mk(ST_OK, oid, x, done ? 32'd0 : open_qty(sh_size[s], sh_exe[s]),
                            done));
        end
        if (batch.size() == 0) batch.insert(batch.size(), mk(ST_NO_FILL, 0, 0, 0, 0));
      end
      KIND_LOOKUP: begin
        if (!found) batch.insert(batch.size(), mk(ST_NOT_FOUND, id, 0, 0, 0));
        else batch.insert(batch.size(),
                          mk(ST_OK, id, 0, open_qty(sh_size[s], sh_exe[s]), 0));
      end
      default: ;
    endcase
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) pending_results.insert(pending_results.size(), batch[i]);
  endfunction

  task automatic send_request(input logic [2:0] kind, input logic [31:0] id,
                              input logic [31:0] price, input logic [31:0] qty,
                              input logic [31:0] exe);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {exe, qty, price, id};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
    apply_request(kind, id, price, qty, exe);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_price(input logic [31:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    lvl_price = v;
  endtask

  task automatic test_directed;
    write_price(32'h7FFF_FFFF);
    send_request(KIND_EXEC, 32'd0, 32'd0, 32'd5, 32'd0);               // empty level
    send_request(KIND_ADD, 32'hFFFF_FFFF, lvl_price, 32'hFFFF_FFFF, 32'd0);
    send_request(KIND_ADD, 32'd1, 32'h8000_0000, 32'd10, 32'd0);       // wrong price
    send_request(KIND_ADD, 32'hFFFF_FFFF, lvl_price, 32'd3, 32'd0);    // duplicate
    send_request(KIND_ADD, 32'hFFFF_FFFF, 32'd1, 32'd3, 32'd0);        // price wins
    send_request(KIND_ADD, 32'd2, lvl_price, 32'd5, 32'd9);            // executed above size
    send_request(KIND_ADD, 32'd3, lvl_price, 32'd20, 32'd4);
    send_request(KIND_MODIFY, 32'd3, 32'd0, 32'd3, 32'd0);             // below executed
    send_request(KIND_MODIFY, 32'd3, 32'd0, 32'd4, 32'd0);             // exactly executed
    send_request(KIND_MODIFY, 32'd9, 32'd0, 32'd4, 32'd0);
    send_request(KIND_LOOKUP, 32'd2, 32'd0, 32'd0, 32'd0);
    send_request(KIND_LOOKUP, 32'd0, 32'd0, 32'd0, 32'd0);
    send_request(KIND_EXEC, 32'd0, 32'd0, 32'd0, 32'd0);               // zero execute
    send_request(KIND_UNUSED_LO, 32'd2, 32'd0, 32'd1, 32'd0);
    send_request(KIND_UNUSED_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(KIND_EXEC, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0);
    send_request(KIND_ADD, 32'd4, lvl_price, 32'd0, 32'd0);            // zero size order
    send_request(KIND_ADD, 32'd5, lvl_price, 32'd8, 32'd1);
    send_request(KIND_EXEC, 32'd0, 32'd0, 32'd3, 32'd0);               // skips zero order
    send_request(KIND_REMOVE, 32'd5, 32'd0, 32'd0, 32'd0);
    send_request(KIND_REMOVE, 32'd5, 32'd0, 32'd0, 32'd0);
    send_request(KIND_ADD, 32'd6, lvl_price, 32'd0, 32'd0);
    send_request(KIND_EXEC, 32'd0, 32'd0, 32'd7, 32'd0);               // only empty orders
  endtask

  task automatic test_full_level;
    write_price(32'h8000_0000);
    hold_left = 400;  // receiver held off at the start; the adds wait behind the held result
    for (int i = 0; i < DEPTH; i++)
      send_request(KIND_ADD, 32'(100 + i), lvl_price, 32'($urandom_range(1, 50)), 32'd0);
    send_request(KIND_ADD, 32'd999, lvl_price, 32'd1, 32'd0);
    send_request(KIND_ADD, 32'd999, 32'd0, 32'd1, 32'd0);
    send_request(KIND_ADD, 32'd100, lvl_price, 32'd1, 32'd0);
    send_request(KIND_LOOKUP, 32'd163, 32'd0, 32'd0, 32'd0);
    send_request(KIND_EXEC, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0);
  endtask

  task automatic test_random_mix(input int n_items);
    logic [2:0] kind;
    logic [31:0] id, price, qty, exe;
    int pick;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (pick < 36) kind = KIND_ADD;
      else if (pick < 48) kind = KIND_REMOVE;
      else if (pick < 60) kind = KIND_MODIFY;
      else if (pick < 78) kind = KIND_EXEC;
      else if (pick < 96) kind = KIND_LOOKUP;
      else kind = 3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
      id = ($urandom_range(19) == 0) ? $urandom : 32'($urandom_range(1, 40));
      price = ($urandom_range(9) == 0) ? $urandom : lvl_price;
      qty = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(0, 120));
      pick = $urandom_range(9);
      if (pick < 6) exe = 32'd0;
      else if (pick < 9) exe = 32'($urandom_range(0, 60));
      else exe = $urandom;
      send_request(kind, id, price, qty, exe);
    end
  endtask

  task automatic test_random_phases;
    int idles[4] = '{0, 46, 0, 32};
    int stalls[4] = '{0, 0, 46, 32};
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = 0;
      stall_pct = 0;
      write_price(($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(0, 4)));
      idle_pct = idles[ph];
      stall_pct = stalls[ph];
      test_random_mix(30);
    end
  endtask

  // receiver side
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic report(input string field, input logic [63:0] want, input logic [63:0] got);
    errors++;
    $display("%0t: %s expected %0h actual %0h", $realtime, field, want, got);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %0h", $realtime, m_axis_tdata);
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (m_axis_tuser !== want.status) report("status", want.status, m_axis_tuser);
        if (m_axis_tdata[31:0] !== want.id) report("result_id", want.id, m_axis_tdata[31:0]);
        if (m_axis_tdata[63:32] !== want.filled)
          report("filled_amount", want.filled, m_axis_tdata[63:32]);
        if (m_axis_tdata[95:64] !== want.remaining)
          report("remaining", want.remaining, m_axis_tdata[95:64]);
        if (m_axis_tdata[96] !== want.done) report("order_done", want.done, m_axis_tdata[96]);
        if (m_axis_tdata[134:97] !== want.total)
          report("level_total", want.total, m_axis_tdata[134:97]);
        if (m_axis_tdata[141:135] !== want.count)
          report("order_count", want.count, m_axis_tdata[141:135]);
        if (m_axis_tlast !== want.last) report("last", want.last, m_axis_tlast);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("price_level_order_queue_core: mismatch");
      $finish;
    end
  end

  initial begin
    lvl_price = 32'd0;
    sh_head = 0;
    sh_tail = 0;
    sh_count = 0;
    sh_total = '0;
    foreach (sh_valid[i]) sh_valid[i] = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_level();
    test_random_phases();
    drain();
    $display("sent %0d requests, checked %0d results over directed, full-level and",
             items_sent, results_seen);
    $display("four random phases with sender gaps and receiver stalls");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("price_level_order_queue_core: match");
    end else begin
      $display("price_level_order_queue_core: mismatch");
    end
    $finish;
  end

endmodule
